// File: rtl/assert_macros.svh
// Assertion macros used by the TLV search RTL.
// Each macro wraps one clocked, reset-qualified concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds on the cycle after.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/tlvs_pkg.sv
// Package for the TLV attribute search block.
// Holds the result and configuration types, status codes and CSR indexes.
`timescale 1ns / 1ps
`default_nettype none

package tlvs_pkg;

   // Result status codes
   localparam logic [1:0] ST_FOUND     = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_TRUNCATED = 2'd2;
   localparam logic [1:0] ST_OVERFLOW  = 2'd3;

   // CSR indexes
   localparam logic [1:0] CSR_TARGET_TYPE   = 2'd0;
   localparam logic [1:0] CSR_BUFFER_LENGTH = 2'd1;
   localparam logic [1:0] CSR_BYTE_ORDER    = 2'd2;

   // Bytes in a record header: 16-bit type plus 16-bit length
   localparam logic [17:0] HEADER_BYTES = 18'd4;

   typedef struct packed {
      logic [15:0] target_type;
      logic [15:0] buffer_length;
      logic        byte_order;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] found_offset;
      logic [15:0] found_length;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/tlvs_scan.sv
// Byte-at-a-time TLV record scanner: scan state and per-byte decision logic.
// Depends on tlvs_pkg for the configuration and result types.
`timescale 1ns / 1ps
`default_nettype none

module tlvs_scan
   import tlvs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] data_byte,
   input  wire logic       start_of_buffer,
   input  wire cfg_type    cfg,
   output logic            res_valid,
   output result_type      res
);

   localparam logic [2:0] PH_TYPE0  = 3'd0;
   localparam logic [2:0] PH_TYPE1  = 3'd1;
   localparam logic [2:0] PH_LEN0   = 3'd2;
   localparam logic [2:0] PH_LEN1   = 3'd3;
   localparam logic [2:0] PH_VALUE  = 3'd4;

   logic [15:0] pos_ff, pos_in, pos_s;
   logic [2:0]  phase_ff, phase_in, phase_s;
   logic [15:0] type_ff, type_in, type_s;
   logic [15:0] len_ff, len_in, len_s;
   logic [15:0] left_ff, left_in, left_s, left_dec;
   logic [15:0] rs_ff, rs_in, rs_s;
   logic        dec_ff, dec_in, dec_s;
   logic [15:0] len_merged;
   logic [15:0] type_merged;
   logic [17:0] hdr_end;
   logic [17:0] chk_start;
   logic        chk;
   logic [2:0]  chk_res;
   logic [2:0]  first_res;

   // Verdict on a record start: {fail, status}
   function automatic logic [2:0] start_check(input logic [17:0] start,
                                              input logic [15:0] buf_len);
      logic [17:0] len_ext;
      len_ext = {2'b00, buf_len};
      if (start >= len_ext)
         return {1'b1, ST_NOT_FOUND};
      else if (start + HEADER_BYTES > len_ext)
         return {1'b1, ST_TRUNCATED};
      else
         return {1'b0, ST_FOUND};
   endfunction

   // Combine two header bytes in the configured order
   function automatic logic [15:0] merge(input logic [7:0] first,
                                         input logic [7:0] second,
                                         input logic big_endian);
      if (big_endian)
         return {first, second};
      else
         return {second, first};
   endfunction

   // Restart the scan on a start-of-buffer byte
   always_comb begin
      pos_s   = start_of_buffer ? 16'd0 : pos_ff;
      phase_s = start_of_buffer ? PH_TYPE0 : phase_ff;
      type_s  = start_of_buffer ? 16'd0 : type_ff;
      len_s   = start_of_buffer ? 16'd0 : len_ff;
      left_s  = start_of_buffer ? 16'd0 : left_ff;
      rs_s    = start_of_buffer ? 16'd0 : rs_ff;
      dec_s   = start_of_buffer ? 1'b0 : dec_ff;
   end

   assign len_merged  = merge(len_s[7:0], data_byte, cfg.byte_order);
   assign type_merged = merge(type_s[7:0], data_byte, cfg.byte_order);
   assign hdr_end     = {2'b00, rs_s} + HEADER_BYTES;
   assign left_dec    = (left_s != 16'd0) ? left_s - 16'd1 : left_s;
   assign first_res   = start_check(18'd0, cfg.buffer_length);

   // Per-byte state update and decision
   always_comb begin
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      type_in   = type_ff;
      len_in    = len_ff;
      left_in   = left_ff;
      rs_in     = rs_ff;
      dec_in    = dec_ff;
      res_valid = 1'b0;
      res       = '0;
      chk       = 1'b0;
      chk_start = '0;
      chk_res   = '0;
      if (accept) begin
         pos_in   = pos_s + 16'd1;
         phase_in = phase_s;
         type_in  = type_s;
         len_in   = len_s;
         left_in  = left_s;
         rs_in    = rs_s;
         dec_in   = dec_s;
         if (dec_s) begin
            // ignore bytes after the decision
         end else if (phase_s == PH_TYPE0 && pos_s == 16'd0 && first_res[2]) begin
            res_valid  = 1'b1;
            res.status = first_res[1:0];
            dec_in     = 1'b1;
         end else begin
            if (phase_s == PH_TYPE0 && pos_s == 16'd0)
               rs_in = 16'd0;
            case (phase_s)
               PH_TYPE0: begin
                  type_in  = {8'd0, data_byte};
                  phase_in = PH_TYPE1;
               end
               PH_TYPE1: begin
                  type_in  = type_merged;
                  phase_in = PH_LEN0;
               end
               PH_LEN0: begin
                  len_in   = {8'd0, data_byte};
                  phase_in = PH_LEN1;
               end
               PH_LEN1: begin
                  len_in = len_merged;
                  if (hdr_end > {2'b00, cfg.buffer_length}) begin
                     res_valid  = 1'b1;
                     res.status = ST_TRUNCATED;
                     dec_in     = 1'b1;
                  end else if (hdr_end + {2'b00, len_merged} >
                               {2'b00, cfg.buffer_length}) begin
                     res_valid  = 1'b1;
                     res.status = ST_OVERFLOW;
                     dec_in     = 1'b1;
                  end else if (type_s == cfg.target_type) begin
                     res_valid        = 1'b1;
                     res.status       = ST_FOUND;
                     res.found_offset = rs_s;
                     res.found_length = len_merged;
                     dec_in           = 1'b1;
                  end else if (len_merged == 16'd0) begin
                     chk       = 1'b1;
                     chk_start = hdr_end;
                  end else begin
                     left_in  = len_merged;
                     phase_in = PH_VALUE;
                  end
               end
               default: begin
                  left_in = left_dec;
                  if (left_dec == 16'd0) begin
                     chk       = 1'b1;
                     chk_start = hdr_end + {2'b00, len_s};
                  end
               end
            endcase
            // Check the next record start
            if (chk) begin
               chk_res = start_check(chk_start, cfg.buffer_length);
               if (chk_res[2]) begin
                  res_valid  = 1'b1;
                  res.status = chk_res[1:0];
                  dec_in     = 1'b1;
               end else begin
                  rs_in    = chk_start[15:0];
                  phase_in = PH_TYPE0;
                  type_in  = 16'd0;
                  len_in   = 16'd0;
                  left_in  = 16'd0;
               end
            end
         end
      end
   end

   // Scan state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 16'd0;
         phase_ff <= PH_TYPE0;
         type_ff  <= 16'd0;
         len_ff   <= 16'd0;
         left_ff  <= 16'd0;
         rs_ff    <= 16'd0;
         dec_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         phase_ff <= phase_in;
         type_ff  <= type_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         rs_ff    <= rs_in;
         dec_ff   <= dec_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/tlvs_out.sv
// Two-entry result buffer: output register plus skid register.
// Depends on tlvs_pkg for the result type and assert_macros.svh for checks.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tlvs_out
   import tlvs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            full,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output result_type      rsp_data
);

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;
   logic       load;

   // Output register can take new data when empty or being drained
   assign load = !out_valid_ff || !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (load) begin
         // drain the skid first, else take the new transaction
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `ASSERT_IMPL(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff,
      "skid holds data while output is empty")
   `ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall,
      out_valid_ff && out_data_ff == $past(skid_data_ff),
      "skid transaction not moved to output")
   `ASSERT_IMPL(a_miss_zero, clock, reset, out_valid_ff && out_data_ff.status != ST_FOUND,
      out_data_ff.found_offset == 16'd0 && out_data_ff.found_length == 16'd0,
      "miss result carries nonzero offset or length")

endmodule

`default_nettype wire

// File: rtl/tlv_attribute_search.sv
// TLV attribute search. Bytes of a buffer of type-length-value records (16-bit type,
// 16-bit length, value bytes) stream in one per transaction; req_start_of_buffer marks
// byte zero. The block reports one result per buffer: the first record whose type
// matches target_type (offset and length), or not found, header truncated or length
// overflow. It takes one byte every clock unless req_stall is high; the per-byte update
// is a combinational state step (a 16-bit type compare and an 18-bit record-end add and
// compare); the result is registered before it reaches rsp. Results pass through a
// two-entry output buffer; req_stall rises only when both entries are held by a
// stalled rsp side. Bytes after the decision are consumed with no result. Write the
// CSRs only while the block is idle.
// Depends on tlvs_pkg, tlvs_scan and tlvs_out.
`timescale 1ns / 1ps
`default_nettype none

module tlv_attribute_search
   import tlvs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_start_of_buffer,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_found_offset,
   output logic [15:0]      rsp_found_length,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       accept;
   logic       res_valid;
   result_type res;
   result_type rsp_data;
   logic       buf_full;

   // Configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TARGET_TYPE:   cfg_in.target_type   = csr_write_data;
            CSR_BUFFER_LENGTH: cfg_in.buffer_length = csr_write_data;
            CSR_BYTE_ORDER:    cfg_in.byte_order    = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_type   <= 16'd0;
         cfg_ff.buffer_length <= 16'd1;
         cfg_ff.byte_order    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept a byte whenever the result buffer has room
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   tlvs_scan u_scan (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_data_byte),
      .start_of_buffer (req_start_of_buffer),
      .cfg             (cfg_ff),
      .res_valid       (res_valid),
      .res             (res)
   );

   tlvs_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status       = rsp_data.status;
   assign rsp_found_offset = rsp_data.found_offset;
   assign rsp_found_length = rsp_data.found_length;

endmodule

`default_nettype wire
